[hdl/crl_pkg.sv]
// ----------------------------------------------------------------------------
// crl_pkg
// shared constants, beat types and controller/datapath interface structs
// ----------------------------------------------------------------------------
package crl_pkg;

    localparam int RAMP_DEPTH    = 16;
    localparam int PALETTE_DEPTH = 256;
    localparam int FRAC_BITS     = 16;

    localparam int RI_W   = (RAMP_DEPTH > 1) ? $clog2(RAMP_DEPTH) : 1;
    localparam int RC_W   = $clog2(RAMP_DEPTH + 1);
    localparam int PAL_AW = $clog2(PALETTE_DEPTH);
    localparam int PSZ_W  = $clog2(PALETTE_DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_CLEAR   = 2'd0,
        REQ_PALETTE = 2'd1,
        REQ_RAMP    = 2'd2,
        REQ_LOOKUP  = 2'd3
    } t_req;

    typedef struct packed {
        t_req               req_type;
        logic [7:0]         entry_index;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic [7:0]         low_red;
        logic [7:0]         low_green;
        logic [7:0]         low_blue;
        logic [7:0]         high_red;
        logic [7:0]         high_green;
        logic [7:0]         high_blue;
        logic signed [31:0] sample_value;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic               found;
        logic               table_defined;
        logic signed [31:0] table_min;
        logic signed [31:0] table_max;
    } t_out_beat;

    typedef struct packed {
        logic load;
        logic apply;
        logic scan_step;
        logic take_ramp;
        logic prep;
        logic set_flat;
        logic pal_take;
        logic mul_a;
        logic mul_b;
        logic div_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_lookup;
        logic has_ramps;
        logic pal_hit;
        logic ramp_hit;
        logic scan_last;
        logic flat;
        logic div_last;
        logic ch_last;
        logic out_free;
    } t_status;

endpackage

[hdl/crl_ram.sv]
// ----------------------------------------------------------------------------
// crl_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module crl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[hdl/crl_ctrl.sv]
// ----------------------------------------------------------------------------
// crl_ctrl
// request sequencer: decode, ramp scan or palette read, per channel multiply and divide
// ----------------------------------------------------------------------------
module crl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  crl_pkg::t_status i_status,
    output crl_pkg::t_cmd    o_cmd
);
    import crl_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_SCAN, ST_CHECK, ST_PAL,
        ST_MUL_A, ST_MUL_B, ST_DIV, ST_FINISH
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!i_status.is_lookup) begin
                    o_cmd.apply = 1'b1;
                    n_state     = ST_FINISH;
                end else if (i_status.has_ramps) begin
                    n_state = ST_SCAN;
                end else if (i_status.pal_hit) begin
                    n_state = ST_PAL;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (i_status.ramp_hit) begin
                    o_cmd.take_ramp = 1'b1;
                    n_state         = ST_CHECK;
                end else if (i_status.scan_last) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_CHECK: begin
                if (i_status.flat) begin
                    o_cmd.set_flat = 1'b1;
                    n_state        = ST_FINISH;
                end else begin
                    o_cmd.prep = 1'b1;
                    n_state    = ST_MUL_A;
                end
            end
            ST_PAL: begin
                o_cmd.pal_take = 1'b1;
                n_state        = ST_FINISH;
            end
            ST_MUL_A: begin
                o_cmd.mul_a = 1'b1;
                n_state     = ST_MUL_B;
            end
            ST_MUL_B: begin
                o_cmd.mul_b = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = i_status.ch_last ? ST_FINISH : ST_MUL_A;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

[hdl/crl_dp.sv]
// ----------------------------------------------------------------------------
// crl_dp
// tables, bounds, ramp scan, interpolation multiply and restoring divide
// ----------------------------------------------------------------------------
module crl_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  crl_pkg::t_in_beat  i_in_beat,
    input  crl_pkg::t_cmd      i_cmd,
    output crl_pkg::t_status   o_status,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output crl_pkg::t_out_beat o_out_beat
);
    import crl_pkg::*;

    t_in_beat r_item;

    // table state
    logic [PALETTE_DEPTH-1:0] r_written;
    logic [PSZ_W-1:0]         r_psize;
    logic [RC_W-1:0]          r_rcount;
    logic signed [31:0]       r_bmin, r_bmax;
    logic signed [31:0]       r_rlo  [RAMP_DEPTH];
    logic signed [31:0]       r_rhi  [RAMP_DEPTH];
    logic [23:0]              r_rlc  [RAMP_DEPTH];
    logic [23:0]              r_rhc  [RAMP_DEPTH];

    // lookup working registers
    logic [RI_W-1:0] r_idx;
    logic            r_flat;
    logic [31:0]     r_d, r_num, r_dn;
    logic [23:0]     r_lc, r_hc;
    logic [39:0]     r_acc, r_rem, r_dsh;
    logic [6:0]      r_q;
    logic [2:0]      r_bit;
    logic [1:0]      r_ch;
    logic [7:0]      r_col [3];
    logic            r_found;

    logic            r_out_valid;
    t_out_beat       r_out;

    logic [23:0] pal_rdata;

    // palette index from the sample, truncated toward zero
    localparam logic signed [32:0] NEG_ONE = -(33'sd1 <<< FRAC_BITS);
    logic [31:0] pidx;
    logic        pal_ok;
    logic        idx_ok;
    logic signed [31:0] q_idx;
    logic [PSZ_W-1:0]   psize_new;
    logic signed [32:0] d_full;
    logic        div_ge;
    logic [7:0]  lo_ch, hi_ch;
    logic [7:0]  q_full;

    always_comb begin
        pidx   = (r_item.sample_value >= 0) ?
                 (32'(r_item.sample_value) >> FRAC_BITS) : 32'd0;
        pal_ok = ((r_item.sample_value >= 0) ||
                  (33'(r_item.sample_value) > NEG_ONE)) &&
                 (pidx < 32'(r_psize));
        idx_ok    = (32'(r_item.entry_index) < 32'(PALETTE_DEPTH));
        q_idx     = 32'(32'(r_item.entry_index) << FRAC_BITS);
        psize_new = PSZ_W'(32'(r_item.entry_index) + 32'd1);
        d_full    = 33'(r_rhi[r_idx]) - 33'(r_rlo[r_idx]);
        div_ge    = (r_rem >= r_dsh);
        q_full    = {r_q, div_ge};
        unique case (r_ch)
            2'd0:    begin lo_ch = r_lc[23:16]; hi_ch = r_hc[23:16]; end
            2'd1:    begin lo_ch = r_lc[15:8];  hi_ch = r_hc[15:8];  end
            default: begin lo_ch = r_lc[7:0];   hi_ch = r_hc[7:0];   end
        endcase
    end

    crl_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_palette (
        .i_clk   (i_clk),
        .i_we    (i_cmd.apply && (r_item.req_type == REQ_PALETTE) && idx_ok),
        .i_waddr (PAL_AW'(r_item.entry_index)),
        .i_wdata ({r_item.low_red, r_item.low_green, r_item.low_blue}),
        .i_raddr (PAL_AW'(pidx)),
        .o_rdata (pal_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written   <= '0;
            r_psize     <= '0;
            r_rcount    <= '0;
            r_bmin      <= '0;
            r_bmax      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.apply) begin
                unique case (r_item.req_type)
                    REQ_CLEAR: begin
                        r_written <= '0;
                        r_psize   <= '0;
                        r_rcount  <= '0;
                        r_bmin    <= '0;
                        r_bmax    <= '0;
                    end
                    REQ_PALETTE: begin
                        if (idx_ok) begin
                            if (r_psize == '0) begin
                                r_bmin <= q_idx;
                                r_bmax <= q_idx;
                            end else begin
                                if (q_idx < r_bmin) r_bmin <= q_idx;
                                if (q_idx > r_bmax) r_bmax <= q_idx;
                            end
                            r_written[PAL_AW'(r_item.entry_index)] <= 1'b1;
                            if (r_psize < psize_new) r_psize <= psize_new;
                        end
                    end
                    REQ_RAMP: begin
                        if (32'(r_rcount) < 32'(RAMP_DEPTH)) begin
                            if (r_rcount == '0) begin
                                r_bmin <= r_item.range_low;
                                r_bmax <= r_item.range_high;
                            end else begin
                                if (r_item.range_low < r_bmin)  r_bmin <= r_item.range_low;
                                if (r_item.range_high > r_bmax) r_bmax <= r_item.range_high;
                            end
                            r_rcount <= r_rcount + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item  <= i_in_beat;
            r_idx   <= '0;
            r_found <= 1'b0;
            r_ch    <= '0;
            r_col   <= '{default: '0};
        end
        if (i_cmd.apply && (r_item.req_type == REQ_RAMP) &&
            (32'(r_rcount) < 32'(RAMP_DEPTH))) begin
            r_rlo[RI_W'(r_rcount)] <= r_item.range_low;
            r_rhi[RI_W'(r_rcount)] <= r_item.range_high;
            r_rlc[RI_W'(r_rcount)] <= {r_item.low_red, r_item.low_green, r_item.low_blue};
            r_rhc[RI_W'(r_rcount)] <= {r_item.high_red, r_item.high_green, r_item.high_blue};
        end
        if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.take_ramp) begin
            r_found <= 1'b1;
            r_flat  <= (d_full <= 0);
            r_d     <= d_full[31:0];
            r_num   <= (r_item.sample_value < r_rlo[r_idx]) ? 32'd0 :
                       32'(33'(r_item.sample_value) - 33'(r_rlo[r_idx]));
            r_lc    <= r_rlc[r_idx];
            r_hc    <= r_rhc[r_idx];
        end
        if (i_cmd.set_flat) begin
            r_col[0] <= r_lc[23:16];
            r_col[1] <= r_lc[15:8];
            r_col[2] <= r_lc[7:0];
        end
        if (i_cmd.prep) begin
            r_dn <= r_d - r_num;
        end
        if (i_cmd.pal_take) begin
            r_found <= 1'b1;
            if (r_written[PAL_AW'(pidx)]) begin
                r_col[0] <= pal_rdata[23:16];
                r_col[1] <= pal_rdata[15:8];
                r_col[2] <= pal_rdata[7:0];
            end
        end
        // lo*(d-num) + hi*num, then divide by d one quotient bit a cycle
        if (i_cmd.mul_a) begin
            r_acc <= 40'(lo_ch) * 40'(r_dn);
        end
        if (i_cmd.mul_b) begin
            r_rem <= r_acc + 40'(hi_ch) * 40'(r_num);
            r_dsh <= {1'b0, r_d, 7'd0};
            r_bit <= 3'd7;
            r_q   <= '0;
        end
        if (i_cmd.div_step) begin
            if (div_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_q   <= q_full[6:0];
            r_bit <= r_bit - 1'b1;
            if (r_bit == 3'd0) begin
                r_col[r_ch] <= q_full;
                if (r_ch != 2'd2) r_ch <= r_ch + 1'b1;
            end
        end
        if (i_cmd.emit) begin
            r_out.out_red       <= r_col[0];
            r_out.out_green     <= r_col[1];
            r_out.out_blue      <= r_col[2];
            r_out.found         <= r_found;
            r_out.table_defined <= (r_psize != '0) || (r_rcount != '0);
            r_out.table_min     <= r_bmin;
            r_out.table_max     <= r_bmax;
        end
    end

    always_comb begin
        o_status.is_lookup = (r_item.req_type == REQ_LOOKUP);
        o_status.has_ramps = (r_rcount != '0);
        o_status.pal_hit   = pal_ok;
        o_status.ramp_hit  = (r_rhi[r_idx] >= r_item.sample_value);
        o_status.scan_last = ((RC_W'(r_idx) + 1'b1) == r_rcount);
        o_status.flat      = r_flat;
        o_status.div_last  = (r_bit == 3'd0);
        o_status.ch_last   = (r_ch == 2'd2);
        o_status.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    a_ramp_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_rcount) <= 32'(RAMP_DEPTH))
        else $error("ramp count beyond table depth");

    a_psize_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_psize) <= 32'(PALETTE_DEPTH))
        else $error("palette size beyond table depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && (r_item.req_type == REQ_CLEAR)) |=>
        (r_rcount == '0) && (r_psize == '0) && (r_written == '0))
        else $error("clear left tables populated");

endmodule

[hdl/color_ramp_lookup.sv]
// ----------------------------------------------------------------------------
// color_ramp_lookup
// maps a q16.16 raster sample to rgb through ramps or a palette
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall carry one request beat: clear,
//   palette write, ramp append or sample lookup
//   output channel: o_out_valid / i_out_stall carry exactly one result beat
//   per request, in request order
//   sequence: table writes and clears pass through decode and finish;
//   palette lookups add a palette read; ramp lookups scan up to 16 ramps,
//   one ramp compare a cycle, then run three channels of multiply and an
//   8 step restoring divide
//   throughput: one request at a time; the next beat is taken once the
//   result has moved into the output register
//   reset: tables empty, bounds zero, no result pending
//   stall: a stalled result holds in the output register; the block may
//   take and work on one more request, then waits to deliver it
// ----------------------------------------------------------------------------
module color_ramp_lookup (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  crl_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output crl_pkg::t_out_beat o_out_beat
);
    import crl_pkg::*;

    // command and status between sequencer and datapath
    t_cmd    cmd;
    t_status status;

    crl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // tables, scan, interpolation and output register
    crl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_beat   (i_in_beat),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule
